FILE: rtl/core/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Types, constants and functions shared by the PCG32 XSH-RR generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

	localparam logic [63:0] SEED_STATE = 64'h853c49e6748fea9b;
	localparam logic [63:0] SEED_INC   = 64'hda3e39cb94b95bdb;
	localparam logic [63:0] MULT       = 64'h5851f42d4c957f2d;
	localparam logic [31:0] FLOAT_MAX  = 32'h3f7fffff;
	localparam int unsigned DIV_STEPS  = 32;

	typedef enum logic [1:0] {
		KIND_RESEED  = 2'd0,
		KIND_RAW     = 2'd1,
		KIND_BOUNDED = 2'd2,
		KIND_FLOAT   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV_THR,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ADVANCE,
		ST_AFTER,
		ST_DIV_RES,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SEED_CLEAR,
		OP_ADD_SEED,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_ADVANCE,
		OP_DIV_THR,
		OP_DIV_RES,
		OP_DIV_STEP,
		OP_THR_LOAD,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_ERR,
		SEL_RAW,
		SEL_FLOAT,
		SEL_REM
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  bound_zero;
		logic  below_thr;
		logic  div_done;
	} status_t;

	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] x;
		logic [31:0] xs;
		logic [4:0]  rot;
		x   = ((s >> 18) ^ s) >> 27;
		xs  = x[31:0];
		rot = s[63:59];
		return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
	endfunction

	function automatic logic [31:0] float_bits(input logic [31:0] r);
		logic [4:0]  p;
		logic [5:0]  ex;
		logic [4:0]  s;
		logic [31:0] rem;
		logic [31:0] half;
		logic [24:0] m;
		logic [31:0] bits;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (r[i]) p = 5'(i);
		end
		ex = {1'b0, p};
		if (p <= 5'd23) begin
			m = 25'(r << (5'd23 - p));
		end else begin
			s    = p - 5'd23;
			rem  = r & ((32'd1 << s) - 32'd1);
			half = 32'd1 << (s - 5'd1);
			m    = 25'(r >> s);
			if (rem > half || (rem == half && m[0])) m = m + 25'd1;
			if (m[24]) begin
				m  = m >> 1;
				ex = ex + 6'd1;
			end
		end
		bits = {1'b0, 8'(ex + 6'd31) + 8'd64, m[22:0]};
		if (r == 32'd0) bits = 32'd0;
		if (bits > FLOAT_MAX) bits = FLOAT_MAX;
		return bits;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcg_ctrl.sv
// ----------------------------------------------------------------------------
// pcg_ctrl
// Request sequencer: steps the datapath through draws, divides and output.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire pcg_pkg::status_t status,
	output pcg_pkg::cmd_t        cmd
);

	pcg_pkg::state_t state_q, state_d;
	logic            pass_q, pass_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcg_pkg::ST_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pass_q      <= pass_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pass_d      = pass_q;
		out_valid_d = out_valid_q && out_stall;
		cmd.op      = pcg_pkg::OP_NONE;
		cmd.sel     = pcg_pkg::SEL_ZERO;
		unique case (state_q)
			pcg_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = pcg_pkg::OP_LOAD;
					state_d = pcg_pkg::ST_DISPATCH;
				end
			end
			pcg_pkg::ST_DISPATCH: begin
				pass_d = 1'b0;
				unique case (status.kind)
					pcg_pkg::KIND_RESEED: begin
						cmd.op  = pcg_pkg::OP_SEED_CLEAR;
						state_d = pcg_pkg::ST_MUL0;
					end
					pcg_pkg::KIND_BOUNDED: begin
						if (status.bound_zero) begin
							cmd.sel = pcg_pkg::SEL_ERR;
							state_d = pcg_pkg::ST_OUT;
						end else begin
							cmd.op  = pcg_pkg::OP_DIV_THR;
							state_d = pcg_pkg::ST_DIV_THR;
						end
					end
					default: state_d = pcg_pkg::ST_MUL0;
				endcase
			end
			pcg_pkg::ST_DIV_THR: begin
				if (status.div_done) begin
					cmd.op  = pcg_pkg::OP_THR_LOAD;
					state_d = pcg_pkg::ST_MUL0;
				end else begin
					cmd.op = pcg_pkg::OP_DIV_STEP;
				end
			end
			pcg_pkg::ST_MUL0: begin
				cmd.op  = pcg_pkg::OP_MUL0;
				state_d = pcg_pkg::ST_MUL1;
			end
			pcg_pkg::ST_MUL1: begin
				cmd.op  = pcg_pkg::OP_MUL1;
				state_d = pcg_pkg::ST_MUL2;
			end
			pcg_pkg::ST_MUL2: begin
				cmd.op  = pcg_pkg::OP_MUL2;
				state_d = pcg_pkg::ST_ADVANCE;
			end
			pcg_pkg::ST_ADVANCE: begin
				cmd.op  = pcg_pkg::OP_ADVANCE;
				state_d = pcg_pkg::ST_AFTER;
			end
			pcg_pkg::ST_AFTER: begin
				unique case (status.kind)
					pcg_pkg::KIND_RESEED: begin
						if (!pass_q) begin
							cmd.op  = pcg_pkg::OP_ADD_SEED;
							pass_d  = 1'b1;
							state_d = pcg_pkg::ST_MUL0;
						end else begin
							state_d = pcg_pkg::ST_OUT;
						end
					end
					pcg_pkg::KIND_RAW: state_d = pcg_pkg::ST_OUT;
					pcg_pkg::KIND_FLOAT: state_d = pcg_pkg::ST_OUT;
					default: begin
						if (status.below_thr) begin
							state_d = pcg_pkg::ST_MUL0;
						end else begin
							cmd.op  = pcg_pkg::OP_DIV_RES;
							state_d = pcg_pkg::ST_DIV_RES;
						end
					end
				endcase
			end
			pcg_pkg::ST_DIV_RES: begin
				if (status.div_done) state_d = pcg_pkg::ST_OUT;
				else cmd.op = pcg_pkg::OP_DIV_STEP;
			end
			pcg_pkg::ST_OUT: begin
				unique case (status.kind)
					pcg_pkg::KIND_RESEED: cmd.sel = pcg_pkg::SEL_ZERO;
					pcg_pkg::KIND_RAW: cmd.sel = pcg_pkg::SEL_RAW;
					pcg_pkg::KIND_FLOAT: cmd.sel = pcg_pkg::SEL_FLOAT;
					default: cmd.sel = status.bound_zero ? pcg_pkg::SEL_ERR : pcg_pkg::SEL_REM;
				endcase
				if (!out_valid_q || !out_stall) begin
					cmd.op      = pcg_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d     = pcg_pkg::ST_IDLE;
				end
			end
			default: state_d = pcg_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != pcg_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcg_datapath.sv
// ----------------------------------------------------------------------------
// pcg_datapath
// Generator state, shared 32x32 multiplier, bit-serial divider, output regs.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             stream_index_wr_en,
	input  wire logic [62:0]      stream_index,
	input  wire logic [1:0]       kind,
	input  wire logic [31:0]      bound,
	input  wire pcg_pkg::cmd_t    cmd,
	output pcg_pkg::status_t      status,
	output logic [31:0]           number,
	output logic                  bound_error
);

	logic [62:0] stream_q;
	logic [63:0] gen_q;
	logic [63:0] inc_q;
	logic [63:0] acc_q;
	logic [1:0]  kind_q;
	logic [31:0] bound_q;
	logic [31:0] r_q;
	logic [31:0] thr_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [5:0]  cnt_q;
	logic [31:0] number_q;
	logic        bound_error_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [32:0] trial;
	logic [32:0] diff;

	always_comb begin
		mul_a = gen_q[31:0];
		mul_b = pcg_pkg::MULT[31:0];
		case (cmd.op)
			pcg_pkg::OP_MUL1: mul_a = gen_q[63:32];
			pcg_pkg::OP_MUL2: mul_b = pcg_pkg::MULT[63:32];
			default: ;
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, bound_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q <= '0;
			gen_q    <= pcg_pkg::SEED_STATE;
			inc_q    <= pcg_pkg::SEED_INC;
			cnt_q    <= '0;
		end else begin
			if (stream_index_wr_en) stream_q <= stream_index;
			case (cmd.op)
				pcg_pkg::OP_SEED_CLEAR: begin
					gen_q <= '0;
					inc_q <= {stream_q, 1'b1};
				end
				pcg_pkg::OP_ADD_SEED: gen_q <= gen_q + pcg_pkg::SEED_STATE;
				pcg_pkg::OP_ADVANCE: gen_q <= acc_q + inc_q;
				pcg_pkg::OP_DIV_THR, pcg_pkg::OP_DIV_RES:
					cnt_q <= 6'(pcg_pkg::DIV_STEPS);
				pcg_pkg::OP_DIV_STEP: cnt_q <= cnt_q - 6'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			pcg_pkg::OP_LOAD: begin
				kind_q  <= kind;
				bound_q <= bound;
			end
			pcg_pkg::OP_MUL0: begin
				acc_q <= prod;
				r_q   <= pcg_pkg::xsh_rr(gen_q);
			end
			pcg_pkg::OP_MUL1, pcg_pkg::OP_MUL2:
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			pcg_pkg::OP_DIV_THR: begin
				rem_q <= '0;
				dvd_q <= 32'd0 - bound_q;
			end
			pcg_pkg::OP_DIV_RES: begin
				rem_q <= '0;
				dvd_q <= r_q;
			end
			pcg_pkg::OP_DIV_STEP: begin
				rem_q <= diff[32] ? trial[31:0] : diff[31:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
			pcg_pkg::OP_THR_LOAD: thr_q <= rem_q;
			pcg_pkg::OP_OUT: begin
				bound_error_q <= (cmd.sel == pcg_pkg::SEL_ERR);
				case (cmd.sel)
					pcg_pkg::SEL_RAW: number_q <= r_q;
					pcg_pkg::SEL_FLOAT: number_q <= pcg_pkg::float_bits(r_q);
					pcg_pkg::SEL_REM: number_q <= rem_q;
					default: number_q <= '0;
				endcase
			end
			default: ;
		endcase
	end

	assign status.kind       = pcg_pkg::kind_t'(kind_q);
	assign status.bound_zero = (bound_q == 32'd0);
	assign status.below_thr  = (r_q < thr_q);
	assign status.div_done   = (cnt_q == 6'd0);
	assign number            = number_q;
	assign bound_error       = bound_error_q;

endmodule

`default_nettype wire

FILE: rtl/core/pcg32_random_generator_core.sv
// ----------------------------------------------------------------------------
// pcg32_random_generator_core
// PCG32 XSH-RR generator: reseed, raw, bounded and float requests.
// ----------------------------------------------------------------------------
//  channel  | signals                        | handshake
//  in       | kind, bound                    | in_valid / in_stall
//  out      | number, bound_error            | out_valid / out_stall
//  config   | stream_index                   | stream_index_wr_en
//
// A draw is three passes through one shared 32x32 multiplier, then the add.
// Bounded requests run the 32-step restoring divider once for the threshold
// and again for the remainder, and redraw while a draw falls below the
// threshold. Reset loads the default seed state and increment. A stalled
// output holds the sequencer in its last step while the next item waits at
// the input.
`default_nettype none

module pcg32_random_generator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        stream_index_wr_en,
	input  wire logic [62:0] stream_index,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] bound,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      number,
	output logic             bound_error
);

	pcg_pkg::cmd_t    cmd;
	pcg_pkg::status_t status;

	pcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pcg_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.stream_index_wr_en (stream_index_wr_en),
		.stream_index       (stream_index),
		.kind               (kind),
		.bound              (bound),
		.cmd                (cmd),
		.status             (status),
		.number             (number),
		.bound_error        (bound_error)
	);

endmodule

`default_nettype wire

FILE: tb/pcg32_random_generator_checker.sv
// ----------------------------------------------------------------------------
// pcg32_random_generator_checker
// Watches the request, result and stream-index ports of the PCG32 core, keeps
// its own generator state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_random_generator_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        stream_index_wr_en,
	input  wire logic [62:0] stream_index,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] bound,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [31:0] number,
	input  wire logic        bound_error,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [31:0] number;
		logic        bound_error;
	} outcome_t;

	logic [62:0] sel_stream;
	logic [63:0] lcg_state;
	logic [63:0] lcg_inc;
	outcome_t    expected_q[$];

	function automatic logic [31:0] permute(input logic [63:0] s);
		logic [31:0] xs;
		logic [4:0]  rot;
		xs  = 32'((s ^ (s >> 18)) >> 27);
		rot = s[63:59];
		if (rot == 5'd0) return xs;
		return (xs >> rot) | (xs << (6'd32 - {1'b0, rot}));
	endfunction

	function automatic logic [31:0] unit_interval_bits(input logic [31:0] r);
		int          msb;
		int          sh;
		logic [31:0] frac;
		logic [31:0] mid;
		logic [31:0] mant;
		logic [31:0] res;
		if (r == 32'd0) return 32'd0;
		msb = 31;
		while (!r[msb]) msb--;
		if (msb <= 23) begin
			mant = r << (23 - msb);
		end else begin
			sh   = msb - 23;
			frac = r & ((32'd1 << sh) - 32'd1);
			mid  = 32'd1 << (sh - 1);
			mant = r >> sh;
			if (frac > mid || (frac == mid && mant[0])) mant++;
			if (mant == 32'h0100_0000) begin
				mant = mant >> 1;
				msb++;
			end
		end
		res = (32'(msb + 95) << 23) | (mant & 32'h007f_ffff);
		if (res > 32'h3f7f_ffff) res = 32'h3f7f_ffff;
		return res;
	endfunction

	task automatic next_word(output logic [31:0] w);
		w = permute(lcg_state);
		lcg_state = lcg_state * 64'h5851_f42d_4c95_7f2d + lcg_inc;
	endtask

	task automatic predict_request(input logic [1:0] k, input logic [31:0] b);
		outcome_t    o;
		logic [31:0] w;
		logic [31:0] thr;
		o = '0;
		case (pcg_pkg::kind_t'(k))
			pcg_pkg::KIND_RESEED: begin
				lcg_state = 64'd0;
				lcg_inc   = {sel_stream, 1'b1};
				next_word(w);
				lcg_state = lcg_state + 64'h853c_49e6_748f_ea9b;
				next_word(w);
			end
			pcg_pkg::KIND_RAW: begin
				next_word(w);
				o.number = w;
			end
			pcg_pkg::KIND_BOUNDED: begin
				if (b == 32'd0) begin
					o.bound_error = 1'b1;
				end else begin
					thr = (32'd0 - b) % b;
					do next_word(w); while (w < thr);
					o.number = w % b;
				end
			end
			default: begin
				next_word(w);
				o.number = unit_interval_bits(w);
			end
		endcase
		expected_q.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			sel_stream = '0;
			lcg_state  = 64'h853c_49e6_748f_ea9b;
			lcg_inc    = 64'hda3e_39cb_94b9_5bdb;
			fail_count = 0;
			expected_q.delete();
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected item: number %h bound_error %b", number, bound_error);
				end else begin
					e = expected_q.pop_front();
					if (number !== e.number || bound_error !== e.bound_error) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h/%b got %h/%b",
								e.number, e.bound_error, number, bound_error);
					end
				end
			end
			if (in_valid && !in_stall) predict_request(kind, bound);
			if (stream_index_wr_en) sel_stream = stream_index;
			pending = expected_q.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_pcg32_random_generator_core.sv
// ----------------------------------------------------------------------------
// tb_pcg32_random_generator_core
// Drives directed and random requests with random gaps and stalls, sweeps the
// stream index between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pcg32_random_generator_core;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        stream_index_wr_en = 1'b0;
	logic [62:0] stream_index = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [31:0] bound = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] number;
	logic        bound_error;
	int          fail_count;
	int          pending;
	logic        calm = 1'b0;
	logic        hold_rx = 1'b0;
	int          quiet_cycles = 0;

	always #1 clk = ~clk;

	pcg32_random_generator_core dut (.*);

	pcg32_random_generator_checker chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else out_stall <= !calm && ($urandom_range(0, 99) < 31);
	end

	task automatic send(input logic [1:0] k, input logic [31:0] b);
		while (!calm && $urandom_range(0, 99) < 31) @(negedge clk);
		kind     <= k;
		bound    <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_and_set(input logic [62:0] v);
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		stream_index       <= v;
		stream_index_wr_en <= 1'b1;
		@(negedge clk);
		stream_index_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 16);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'hffff_ffff - $urandom_range(0, 3);
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send(pcg_pkg::KIND_RAW, 32'd0);
		send(pcg_pkg::KIND_FLOAT, 32'hffff_ffff);
		send(pcg_pkg::KIND_BOUNDED, 32'd0);
		send(pcg_pkg::KIND_BOUNDED, 32'd1);
		send(pcg_pkg::KIND_BOUNDED, 32'd2);
		send(pcg_pkg::KIND_BOUNDED, 32'd3);
		send(pcg_pkg::KIND_BOUNDED, 32'h8000_0001);
		send(pcg_pkg::KIND_BOUNDED, 32'hffff_ffff);
		send(pcg_pkg::KIND_BOUNDED, 32'haaaa_aaaa);
		send(pcg_pkg::KIND_BOUNDED, 32'h5555_5555);
		send(pcg_pkg::KIND_RESEED, 32'd0);
		send(pcg_pkg::KIND_FLOAT, 32'd0);
		drain_and_set({63{1'b1}});
		send(pcg_pkg::KIND_RESEED, 32'd7);
		send(pcg_pkg::KIND_RAW, 32'd0);
		send(pcg_pkg::KIND_FLOAT, 32'd0);
		drain_and_set(63'h2aaa_aaaa_aaaa_aaaa);
		send(pcg_pkg::KIND_RESEED, 32'd0);
		send(pcg_pkg::KIND_BOUNDED, 32'd10);
		drain_and_set(63'h5555_5555_5555_5555);
		send(pcg_pkg::KIND_RESEED, 32'd0);
		send(pcg_pkg::KIND_RAW, 32'd0);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: drain_and_set('0);
				5: drain_and_set({63{1'b1}});
				default: drain_and_set(63'({$urandom, $urandom}));
			endcase
			if (ph == 2) calm = 1'b1;
			if (ph == 3) calm = 1'b0;
			if (ph == 4) begin
				fork
					begin
						hold_rx = 1'b1;
						repeat (400) @(negedge clk);
						hold_rx = 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 305; i++) begin
				case ($urandom_range(0, 9))
					0: send(pcg_pkg::KIND_RESEED, $urandom);
					1, 2, 3: send(pcg_pkg::KIND_RAW, $urandom);
					4, 5, 6: send(pcg_pkg::KIND_BOUNDED, pick_bound());
					default: send(pcg_pkg::KIND_FLOAT, $urandom);
				endcase
			end
		end
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/pcg_pkg.sv
rtl/core/pcg_ctrl.sv
rtl/core/pcg_datapath.sv
rtl/core/pcg32_random_generator_core.sv
tb/pcg32_random_generator_checker.sv
tb/tb_pcg32_random_generator_core.sv
